FILE: src/swm_pkg.sv
// shared constants for the sliding window maximum block
package swm_pkg;

   localparam int MAX_WINDOW_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int CSR_W            = 7;
   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 7'd3;

endpackage

FILE: src/swm_cell.sv
// one queue cell: holds a candidate of fixed age and hands it to the next cell each beat
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int WIN_W        = 7,
   parameter int INDEX        = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           start,
   input  logic [WIN_W-1:0]               window,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           prev_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
   output logic                           valid,
   output logic signed [SAMPLE_WIDTH-1:0] value
);

   localparam logic [WIN_W-1:0] AGE = WIN_W'(INDEX);

   logic                           valid_ff;
   logic                           valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff;

   // cell 0 always takes the new sample; others drop on start, expiry or a larger newcomer
   always_comb begin
      valid_in = prev_valid && (AGE < window) && !(prev_value < sample);
      if (start && (INDEX != 0)) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= prev_value;
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

FILE: src/swm_max_tree.sv
// pipelined max tree over the cell row, one register level per tree level
module swm_max_tree #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int CELLS        = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           tag_in,
   input  logic [CELLS-1:0]               leaf_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] leaf_value [CELLS],
   output logic                           out_valid,
   output logic signed [SAMPLE_WIDTH-1:0] out_value
);

   localparam int LEVELS = ($clog2(CELLS) < 1) ? 1 : $clog2(CELLS);
   localparam int LEAVES = 1 << LEVELS;

   logic                           pad_valid [LEAVES];
   logic signed [SAMPLE_WIDTH-1:0] pad_value [LEAVES];
   logic                           node_valid_ff [1:LEAVES-1];
   logic signed [SAMPLE_WIDTH-1:0] node_value_ff [1:LEAVES-1];
   logic [LEVELS:0]                tag_ff;

   for (genvar i = 0; i < LEAVES; i++) begin : g_pad
      if (i < CELLS) begin : g_real
         assign pad_valid[i] = leaf_valid[i];
         assign pad_value[i] = leaf_value[i];
      end else begin : g_empty
         assign pad_valid[i] = 1'b0;
         assign pad_value[i] = '0;
      end
   end

   for (genvar n = 1; n < LEAVES; n++) begin : g_node
      logic                           a_valid;
      logic                           b_valid;
      logic signed [SAMPLE_WIDTH-1:0] a_value;
      logic signed [SAMPLE_WIDTH-1:0] b_value;
      logic                           node_valid_in;
      logic signed [SAMPLE_WIDTH-1:0] node_value_in;

      if (2 * n >= LEAVES) begin : g_from_leaf
         assign a_valid = pad_valid[2*n-LEAVES];
         assign a_value = pad_value[2*n-LEAVES];
         assign b_valid = pad_valid[2*n+1-LEAVES];
         assign b_value = pad_value[2*n+1-LEAVES];
      end else begin : g_from_node
         assign a_valid = node_valid_ff[2*n];
         assign a_value = node_value_ff[2*n];
         assign b_valid = node_valid_ff[2*n+1];
         assign b_value = node_value_ff[2*n+1];
      end

      // empty cells lose every compare
      always_comb begin
         node_valid_in = a_valid | b_valid;
         if (a_valid && b_valid) begin
            node_value_in = (a_value > b_value) ? a_value : b_value;
         end else if (a_valid) begin
            node_value_in = a_value;
         end else begin
            node_value_in = b_value;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            node_valid_ff[n] <= node_valid_in;
            node_value_ff[n] <= node_value_in;
         end
      end
   end

   // marks which tree slots carry a result that is owed to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= {tag_ff[LEVELS-1:0], tag_in};
      end
   end

   assign out_valid = tag_ff[LEVELS];
   assign out_value = node_value_ff[1];

endmodule

FILE: src/sliding_window_maximum.sv
// top level of the sliding window maximum block
// Takes one sample per clock through a row of MAX_WINDOW cells, where cell k holds the
// candidate of age k and every cell moves its entry one step down the row on each input
// beat. A result passes through the cell registers and then through the registered max
// tree that reduces the row; the sustained rate stays at one sample per
// cycle while the result side is not stalled, and a stalled result holds the whole pipe.
// No result comes out until window_size samples of the current array have arrived;
// req_start_new empties the queue before its sample is taken. window_size 0 acts as 1,
// values above MAX_WINDOW act as MAX_WINDOW, and a new size applies from the next sample.
module sliding_window_maximum
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_W-1:0]               csr_window_size,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_start_new,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_window_max
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (WIN_W > CSR_W) ? WIN_W : CSR_W;

   logic [CSR_W-1:0]               window_size_ff;
   logic [CMP_W-1:0]               size_ext;
   logic [WIN_W-1:0]               window;
   logic [WIN_W-1:0]               fill_ff;
   logic [WIN_W-1:0]               fill_in;
   logic [WIN_W-1:0]               fill_base;
   logic                           emit;
   logic                           accept;
   logic                           advance;
   logic [MAX_WINDOW-1:0]          cand_valid;
   logic signed [SAMPLE_WIDTH-1:0] cand_value [MAX_WINDOW];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         window_size_ff <= csr_window_size;
      end
   end

   assign size_ext = CMP_W'(window_size_ff);

   always_comb begin
      if (size_ext == '0) begin
         window = WIN_W'(1);
      end else if (size_ext > CMP_W'(MAX_WINDOW)) begin
         window = WIN_W'(MAX_WINDOW);
      end else begin
         window = WIN_W'(size_ext);
      end
   end

   // the whole pipe freezes while a finished result waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && !req_stall;

   // fill count is clamped to a shrunken window before it counts on
   always_comb begin
      if (req_start_new) begin
         fill_base = '0;
      end else if (fill_ff > window) begin
         fill_base = window;
      end else begin
         fill_base = fill_ff;
      end
      fill_in = (fill_base < window) ? fill_base + WIN_W'(1) : fill_base;
      emit    = (fill_in == window);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      logic                           prev_valid;
      logic signed [SAMPLE_WIDTH-1:0] prev_value;

      if (k == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_value = req_sample;
      end else begin : g_link
         assign prev_valid = cand_valid[k-1];
         assign prev_value = cand_value[k-1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .WIN_W        (WIN_W),
         .INDEX        (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (accept),
         .start      (req_start_new),
         .window     (window),
         .sample     (req_sample),
         .prev_valid (prev_valid),
         .prev_value (prev_value),
         .valid      (cand_valid[k]),
         .value      (cand_value[k])
      );
   end

   swm_max_tree #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CELLS        (MAX_WINDOW)
   ) u_tree (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .tag_in     (accept && emit),
      .leaf_valid (cand_valid),
      .leaf_value (cand_value),
      .out_valid  (rsp_valid),
      .out_value  (rsp_window_max)
   );

   // the newest sample always enters the queue
   assert property (@(posedge clock) disable iff (reset)
      accept |=> cand_valid[0])
      else $error("newest sample missing from cell 0");

   // a new array leaves only its first sample queued
   assert property (@(posedge clock) disable iff (reset)
      accept && req_start_new |=> $countones(cand_valid) == 1)
      else $error("queue not emptied on start of array");

   // no beat taken means the queue holds still
   assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(cand_valid))
      else $error("queue changed while input stalled");

   // fill count never runs past the largest window
   assert property (@(posedge clock) disable iff (reset)
      accept |=> fill_ff <= WIN_W'(MAX_WINDOW))
      else $error("fill count out of range");

endmodule
